[rtl/core/lca_pkg.sv]
// shared constants and types for the life cellular automaton
package lca_pkg;

    localparam int WIDTH   = 64;
    localparam int HEIGHT  = 64;
    localparam int COORD_W = 6;
    localparam int GEN_W   = 16;

    localparam int COL_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int ADDR_W = $clog2(HEIGHT);
    localparam int CNT_W  = $clog2(HEIGHT + 1);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    localparam int         NBR_W         = 4;
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // one column of the three-row window
    typedef struct packed {
        logic up;
        logic mid;
        logic dn;
    } win_bits_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

endpackage

[rtl/core/lca_ram.sv]
// generic simple dual-port ram with registered read
module lca_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lca_cell.sv]
// one column cell: holds three window rows and evaluates the b3/s23 rule
module lca_cell (
    input  logic              clk,
    input  lca_pkg::win_ctrl_t ctrl,
    input  logic              load_bit,
    input  lca_pkg::win_bits_t left,
    input  lca_pkg::win_bits_t right,
    output lca_pkg::win_bits_t win,
    output logic              next_bit
);
    import lca_pkg::*;

    win_bits_t        win_reg;
    logic [NBR_W-1:0] nbr_cnt;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            win_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            win_reg.up  <= win_reg.mid;
            win_reg.mid <= win_reg.dn;
            win_reg.dn  <= load_bit;
        end
    end

    assign nbr_cnt = NBR_W'(left.up) + NBR_W'(left.mid) + NBR_W'(left.dn)
                   + NBR_W'(right.up) + NBR_W'(right.mid) + NBR_W'(right.dn)
                   + NBR_W'(win_reg.up) + NBR_W'(win_reg.dn);

    assign next_bit = (nbr_cnt == BIRTH_COUNT)
                   || (win_reg.mid && (nbr_cnt == SURVIVE_COUNT));
    assign win = win_reg;

endmodule

[rtl/core/life_cellular_automaton.sv]
// top level: grid store, sweep control and the row of rule cells
// A command is taken when start is high and busy is low. Write and read pass
// through the ram read, the merge or pick of the bit and the output register
// before the done strobe. A step streams every row out of the grid ram, one
// row per cycle through the single ram read port, through a three-row window
// held in a row of WIDTH cells and writes each new row back in place once the
// window has filled. Results appear for one cycle with done high and cannot be
// held off. generation shows the count of steps and changes only with done. The
// grid reads as all dead after reset through per-row valid bits, so no clearing
// pass is needed.
module life_cellular_automaton (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [lca_pkg::COORD_W-1:0] col,
    input  logic [lca_pkg::COORD_W-1:0] row,
    input  logic                       cell_in,
    output logic                       done,
    output logic                       cell_out,
    output logic [lca_pkg::GEN_W-1:0]  generation
);
    import lca_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_ACCESS, ST_FINISH, ST_SWEEP} state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg;
    logic [COORD_W-1:0]  col_reg, row_reg;
    logic                cell_in_reg, inside_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                ld_v_reg, dn_v_reg, mid_v_reg;
    logic [ADDR_W-1:0]   ld_idx_reg, dn_idx_reg, mid_idx_reg;
    logic                cap_reg, done_reg, cell_out_reg, rd_valid_reg;
    logic [GEN_W-1:0]    gen_reg;
    logic [HEIGHT-1:0]   row_valid_reg;

    logic                accept, hit, hit_bit, sweep_last, rd_more;
    logic [COL_W-1:0]    col_addr;
    logic [ADDR_W-1:0]   row_addr;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WIDTH-1:0]    ram_wdata, ram_rdata, rd_row, mod_row, load_row, next_row;
    win_ctrl_t           win_ctrl;
    win_bits_t           cell_win [WIDTH];

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign col_addr = COL_W'(col_reg);
    assign row_addr = ADDR_W'(row_reg);
    assign rd_row   = rd_valid_reg ? ram_rdata : '0;
    assign load_row = ld_v_reg ? rd_row : '0;
    assign rd_more  = (rd_cnt_reg < CNT_W'(HEIGHT));

    always_comb
    begin
        mod_row           = rd_row;
        mod_row[col_addr] = cell_in_reg;
    end

    // the window middle row is the one being rewritten
    assign hit        = mid_v_reg && (mid_idx_reg == row_addr);
    assign hit_bit    = next_row[col_addr];
    assign sweep_last = mid_v_reg && (mid_idx_reg == ADDR_W'(HEIGHT - 1));

    assign ram_re    = (state_reg == ST_ACCESS) || ((state_reg == ST_SWEEP) && rd_more);
    assign ram_raddr = (state_reg == ST_ACCESS) ? row_addr : rd_cnt_reg[ADDR_W-1:0];
    assign ram_we    = ((state_reg == ST_FINISH) && (cmd_reg == CMD_WRITE) && inside_reg)
                    || ((state_reg == ST_SWEEP) && mid_v_reg);
    assign ram_waddr = (state_reg == ST_SWEEP) ? mid_idx_reg : row_addr;
    assign ram_wdata = (state_reg == ST_SWEEP) ? next_row : mod_row;

    assign win_ctrl.shift = (state_reg == ST_SWEEP);
    assign win_ctrl.clear = accept && (cmd == CMD_STEP);

    lca_ram #(
        .DATA_W (WIDTH),
        .DEPTH  (HEIGHT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar c = 0; c < WIDTH; c++)
    begin : g_cells
        win_bits_t left_nbr, right_nbr;
        if (c == 0)
        begin : g_left_edge
            assign left_nbr = '0;
        end
        else
        begin : g_left_inner
            assign left_nbr = cell_win[c-1];
        end
        if (c == WIDTH - 1)
        begin : g_right_edge
            assign right_nbr = '0;
        end
        else
        begin : g_right_inner
            assign right_nbr = cell_win[c+1];
        end
        lca_cell u_cell (
            .clk      (clk),
            .ctrl     (win_ctrl),
            .load_bit (load_row[c]),
            .left     (left_nbr),
            .right    (right_nbr),
            .win      (cell_win[c]),
            .next_bit (next_row[c])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == CMD_STEP) ? ST_SWEEP : ST_ACCESS;
                end
            end
            ST_ACCESS: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_READ;
            col_reg       <= '0;
            row_reg       <= '0;
            cell_in_reg   <= 1'b0;
            inside_reg    <= 1'b0;
            rd_cnt_reg    <= '0;
            ld_v_reg      <= 1'b0;
            dn_v_reg      <= 1'b0;
            mid_v_reg     <= 1'b0;
            ld_idx_reg    <= '0;
            dn_idx_reg    <= '0;
            mid_idx_reg   <= '0;
            cap_reg       <= 1'b0;
            done_reg      <= 1'b0;
            cell_out_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            gen_reg       <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_valid_reg <= row_valid_reg[ram_raddr];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg     <= cmd;
                        col_reg     <= col;
                        row_reg     <= row;
                        cell_in_reg <= cell_in;
                        inside_reg  <= (int'(col) < WIDTH) && (int'(row) < HEIGHT);
                        rd_cnt_reg  <= '0;
                        ld_v_reg    <= 1'b0;
                        dn_v_reg    <= 1'b0;
                        mid_v_reg   <= 1'b0;
                        cap_reg     <= 1'b0;
                    end
                end
                ST_ACCESS:
                begin
                end
                ST_FINISH:
                begin
                    done_reg     <= 1'b1;
                    cell_out_reg <= inside_reg
                                 && ((cmd_reg == CMD_WRITE) ? cell_in_reg : rd_row[col_addr]);
                end
                ST_SWEEP:
                begin
                    if (rd_more)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                        ld_v_reg   <= 1'b1;
                        ld_idx_reg <= rd_cnt_reg[ADDR_W-1:0];
                    end
                    else
                    begin
                        ld_v_reg <= 1'b0;
                    end
                    // row tags move along with the window
                    dn_v_reg    <= ld_v_reg;
                    dn_idx_reg  <= ld_idx_reg;
                    mid_v_reg   <= dn_v_reg;
                    mid_idx_reg <= dn_idx_reg;
                    if (hit)
                    begin
                        cap_reg <= hit_bit;
                    end
                    if (sweep_last)
                    begin
                        done_reg     <= 1'b1;
                        gen_reg      <= gen_reg + GEN_W'(1);
                        cell_out_reg <= inside_reg && (hit ? hit_bit : cap_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign cell_out   = cell_out_reg;
    assign generation = gen_reg;

endmodule

[rtl/core/lca_checker.sv]
// port-level checker for the life cellular automaton and its bind
module lca_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 cmd,
    input logic [lca_pkg::COORD_W-1:0] col,
    input logic [lca_pkg::COORD_W-1:0] row,
    input logic                       cell_in,
    input logic                       done,
    input logic                       cell_out,
    input logic [lca_pkg::GEN_W-1:0]  generation
);
    import lca_pkg::*;

    // a result never overlaps work in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // cell access finishes in fixed latency
    a_access_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd != CMD_STEP)) |-> ##3 done)
        else $error("read or write result late");

    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (generation != $past(generation))
            |-> (done && (generation == $past(generation) + GEN_W'(1))))
        else $error("generation moved outside a step result");

endmodule

bind life_cellular_automaton lca_checker u_lca_checker (.*);

[tb/life_cellular_automaton_test.sv]
// self-checking testbench for the life cellular automaton with a bit-level grid predictor
`timescale 1ns / 1ps

module life_cellular_automaton_test;

    import lca_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         RANDOM_ITEMS = 1480;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         SETTLE_CYCLES = HEIGHT + 20;

    typedef struct {
        logic [1:0]         op;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        logic               val;
        bit                 drain_first;
    } life_cmd_t;

    typedef struct {
        logic             alive;
        logic [GEN_W-1:0] gen;
    } life_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         cmd = CMD_WRITE;
    logic [COORD_W-1:0] col = '0;
    logic [COORD_W-1:0] row = '0;
    logic               cell_in = 1'b0;
    logic               done;
    logic               cell_out;
    logic [GEN_W-1:0]   generation;

    life_cmd_t    pending_cmds[$];
    life_answer_t expected_answers[$];

    bit [WIDTH-1:0]   life_grid [HEIGHT];
    logic [GEN_W-1:0] gen_count = '0;

    bit took_transfer = 1'b0;
    int launched_count = 0;
    int cycle_count = 0;
    int error_count = 0;

    life_cellular_automaton u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .col        (col),
        .row        (row),
        .cell_in    (cell_in),
        .done       (done),
        .cell_out   (cell_out),
        .generation (generation)
    );

    always #2 clk = ~clk;

    // cells off the grid read as dead, so edges do not wrap
    function automatic bit cell_alive(int r, int c);
        if (r < 0 || r >= HEIGHT || c < 0 || c >= WIDTH)
            return 1'b0;
        return life_grid[r][c];
    endfunction

    function automatic void advance_generation();
        bit [WIDTH-1:0] next_grid [HEIGHT];
        int             n;
        bit             self_alive;
        for (int r = 0; r < HEIGHT; r++)
        begin
            for (int c = 0; c < WIDTH; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            n += int'(cell_alive(r + dr, c + dc));
                self_alive = life_grid[r][c];
                next_grid[r][c] = self_alive ? (n == SURVIVE_COUNT || n == BIRTH_COUNT)
                                             : (n == BIRTH_COUNT);
            end
        end
        life_grid = next_grid;
        gen_count = gen_count + GEN_W'(1);
    endfunction

    function automatic life_answer_t apply_command(life_cmd_t item);
        life_answer_t ans;
        bit           on_grid;
        on_grid = (item.c < WIDTH) && (item.r < HEIGHT);
        if (item.op == CMD_WRITE)
        begin
            if (on_grid)
                life_grid[item.r][item.c] = item.val;
        end
        else if (item.op == CMD_STEP)
        begin
            advance_generation();
        end
        ans.alive = on_grid ? cell_alive(item.r, item.c) : 1'b0;
        ans.gen   = gen_count;
        return ans;
    endfunction

    task automatic add_cmd(logic [1:0] op, int c, int r, bit val, bit drain_first);
        life_cmd_t item;
        item.op          = op;
        item.c           = c[COORD_W-1:0];
        item.r           = r[COORD_W-1:0];
        item.val         = val;
        item.drain_first = drain_first;
        pending_cmds.push_back(item);
    endtask

    function automatic int near_coord(int base);
        return (base + $urandom_range(4) - 2) & ((1 << COORD_W) - 1);
    endfunction

    function automatic int pick_base();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return 0;
        if (pick < 25)
            return (1 << COORD_W) - 1;
        return $urandom_range((1 << COORD_W) - 1);
    endfunction

    // seed a small patch, then step and probe it
    task automatic add_pattern_run();
        int base_r;
        int base_c;
        base_r = pick_base();
        base_c = pick_base();
        repeat ($urandom_range(10, 3))
            add_cmd(CMD_WRITE, near_coord(base_c), near_coord(base_r),
                    $urandom_range(99) < 75, 1'b0);
        repeat ($urandom_range(4, 1))
        begin
            add_cmd(CMD_STEP, near_coord(base_c), near_coord(base_r),
                    1'($urandom_range(1)), $urandom_range(99) < 1);
            repeat ($urandom_range(2))
                add_cmd(($urandom_range(9) == 0) ? CMD_SPARE : CMD_READ,
                        near_coord(base_c), near_coord(base_r),
                        1'($urandom_range(1)), 1'b0);
        end
    endtask

    task automatic build_stimulus();
        int target;
        add_cmd(CMD_READ,  0, 0, 1'b0, 1'b0);
        add_cmd(CMD_STEP,  5, 5, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 0, 0, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 63, 0, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 0, 63, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 63, 63, 1'b1, 1'b0);
        add_cmd(CMD_SPARE, 63, 63, 1'b0, 1'b0);
        add_cmd(CMD_READ,  0, 63, 1'b1, 1'b0);
        // blinker on the top edge loses its upper half
        add_cmd(CMD_WRITE, 30, 0, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 31, 0, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 32, 0, 1'b1, 1'b0);
        add_cmd(CMD_STEP,  31, 1, 1'b0, 1'b0);
        add_cmd(CMD_READ,  31, 0, 1'b0, 1'b0);
        add_cmd(CMD_READ,  30, 0, 1'b0, 1'b0);
        add_cmd(CMD_WRITE, 31, 0, 1'b0, 1'b0);
        add_cmd(CMD_WRITE, 0, 0, 1'b0, 1'b0);
        add_cmd(CMD_STEP,  63, 63, 1'b1, 1'b1);
        add_cmd(CMD_READ,  63, 63, 1'b0, 1'b0);
        add_cmd(CMD_WRITE, 63, 31, 1'b1, 1'b0);
        add_cmd(CMD_WRITE, 63, 31, 1'b1, 1'b0);
        // the spare command must not write
        add_cmd(CMD_SPARE, 62, 31, 1'b1, 1'b0);
        add_cmd(CMD_READ,  62, 31, 1'b0, 1'b0);
        add_cmd(CMD_STEP,  62, 31, 1'b0, 1'b1);

        target = pending_cmds.size() + RANDOM_ITEMS;
        while (pending_cmds.size() < target)
        begin
            if ($urandom_range(99) < 70)
                add_pattern_run();
            else
                add_cmd(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                        1'($urandom_range(1)), $urandom_range(99) < 1);
        end
    endtask

    // sender: holds an item until it is taken, then maybe idles
    always @(negedge clk)
    begin : drive_cmds
        life_cmd_t item;
        bit        may_idle;
        if (rst_n && (!start || took_transfer))
        begin
            may_idle = !(launched_count >= 500 && launched_count < 800);
            if (pending_cmds.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (pending_cmds[0].drain_first && expected_answers.size() != 0)
            begin
                start <= 1'b0;
            end
            else if (may_idle && $urandom_range(99) < 12)
            begin
                start <= 1'b0;
            end
            else
            begin
                item = pending_cmds.pop_front();
                cmd     <= item.op;
                col     <= item.c;
                row     <= item.r;
                cell_in <= item.val;
                start   <= 1'b1;
                launched_count++;
            end
        end
    end

    // receiver: check results first, then record the transfer taken at this edge
    always @(posedge clk)
    begin : watch_results
        life_cmd_t    item;
        life_answer_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles", $time, cycle_count);
                $display("life_cellular_automaton_test failed");
                $finish;
            end
            if (done === 1'b1)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: result expected none actual cell_out=%0b generation=%0d",
                             $time, cell_out, generation);
                    error_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (cell_out !== want.alive)
                    begin
                        $display("%0t: cell_out expected %0b actual %0b",
                                 $time, want.alive, cell_out);
                        error_count++;
                    end
                    if (generation !== want.gen)
                    begin
                        $display("%0t: generation expected %0d actual %0d",
                                 $time, want.gen, generation);
                        error_count++;
                    end
                end
            end
            took_transfer = start && (busy === 1'b0);
            if (took_transfer)
            begin
                item.op  = cmd;
                item.c   = col;
                item.r   = row;
                item.val = cell_in;
                item.drain_first = 1'b0;
                expected_answers.push_back(apply_command(item));
            end
        end
    end

    initial
    begin
        for (int r = 0; r < HEIGHT; r++)
            life_grid[r] = '0;
        build_stimulus();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_answers.size() == 0)
            $display("life_cellular_automaton_test passed");
        else
            $display("life_cellular_automaton_test failed");
        $finish;
    end

endmodule
